[rtl/core/exlex_pkg.sv]
// Shared types, constants and helper functions for the expression lexer.
// Included by every module of the lexer; depends on nothing else.
`timescale 1ns / 1ps

package exlex_pkg;

    // Width of the running byte offset; it wraps at this many bits.
    localparam int POSITION_BITS = 16;
    // Token length saturates at this count.
    localparam int MAX_TOKEN_LEN = 255;

    localparam int POS_W = POSITION_BITS;
    localparam int LEN_W = $clog2(MAX_TOKEN_LEN + 1);

    // Number of characters in the keyword "print".
    localparam int KW_LEN = 5;
    localparam int KW_W   = 3;

    // Result queue: room for the two tokens one byte may cause, plus slack.
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Character codes the scanner looks for.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_EQUALS     = 8'h3D;
    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_CR         = 8'h0D;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUMBER,
        MODE_IDENT,
        MODE_STRING,
        MODE_ERROR
    } t_mode;

    // Token kinds as reported on the output.
    typedef enum logic [3:0] {
        KIND_NUMBER = 4'd0,
        KIND_IDENT  = 4'd1,
        KIND_PRINT  = 4'd2,
        KIND_STRING = 4'd3,
        KIND_PLUS   = 4'd4,
        KIND_MINUS  = 4'd5,
        KIND_MUL    = 4'd6,
        KIND_DIV    = 4'd7,
        KIND_LPAREN = 4'd8,
        KIND_RPAREN = 4'd9,
        KIND_ASSIGN = 4'd10,
        KIND_SEMI   = 4'd11,
        KIND_END    = 4'd12,
        KIND_BAD    = 4'd13,
        KIND_UNTERM = 4'd14
    } t_kind;

    // One result word.
    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [7:0]  length;
        logic        ovf;
        logic        last;
    } t_token;

    // Up to two tokens produced by one accepted byte, already in order.
    typedef struct packed {
        logic   v0;
        logic   v1;
        t_token tok0;
        t_token tok1;
    } t_scan_res;

    // Character of the keyword at a given position.
    function automatic logic [7:0] kw_char(input logic [KW_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h70; // p
            3'd1:    c = 8'h72; // r
            3'd2:    c = 8'h69; // i
            3'd3:    c = 8'h6E; // n
            3'd4:    c = 8'h74; // t
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // Kind of a single-character token; anything unknown is a bad character.
    function automatic t_kind single_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_MUL;
            CH_SLASH:  k = KIND_DIV;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_EQUALS: k = KIND_ASSIGN;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_BAD;
        endcase
        return k;
    endfunction

endpackage

[rtl/core/exlex_scan.sv]
// Byte scanner of the expression lexer: mode register, token tracking and
// per-byte classification. Depends on exlex_pkg.
`timescale 1ns / 1ps

module exlex_scan
    import exlex_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_ch,
    input  logic       i_end,
    output t_scan_res  o_res
);

    t_mode            r_mode, n_mode;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [POS_W-1:0] r_tstart, n_tstart;
    logic [LEN_W-1:0] r_tlen, n_tlen;
    logic             r_sat, n_sat;
    logic [KW_W-1:0]  r_kwp, n_kwp;
    logic             r_kwdead, n_kwdead;

    logic             text_end;
    logic             do_fresh;
    logic             flush_v, fresh_v;
    t_kind            flush_kind;
    t_kind            op_kind;
    t_token           flush_tok, fresh_tok;
    logic             kw_hit;

    // Scanner state, updated once for every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_tstart <= '0;
            r_tlen   <= '0;
            r_sat    <= 1'b0;
            r_kwp    <= '0;
            r_kwdead <= 1'b0;
        end else if (i_accept) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_tstart <= n_tstart;
            r_tlen   <= n_tlen;
            r_sat    <= n_sat;
            r_kwp    <= n_kwp;
            r_kwdead <= n_kwdead;
        end
    end

    // A zero byte ends the text just as the end flag does.
    assign text_end = i_end || (i_ch == CH_NUL);
    assign op_kind  = single_kind(i_ch);
    assign kw_hit   = !r_kwdead && (r_kwp < KW_W'(KW_LEN)) && (i_ch == kw_char(r_kwp));

    // Next state and the tokens this byte produces.
    always_comb begin
        n_mode     = r_mode;
        n_pos      = r_pos + POS_W'(1);
        n_tstart   = r_tstart;
        n_tlen     = r_tlen;
        n_sat      = r_sat;
        n_kwp      = r_kwp;
        n_kwdead   = r_kwdead;
        do_fresh   = 1'b0;
        flush_v    = 1'b0;
        fresh_v    = 1'b0;
        flush_kind = KIND_NUMBER;

        fresh_tok.kind   = op_kind;
        fresh_tok.start  = 16'(r_pos);
        fresh_tok.length = 8'd1;
        fresh_tok.ovf    = 1'b0;
        fresh_tok.last   = 1'b0;

        if (text_end) begin
            // Flush whatever is pending, then report the end of text.
            flush_v    = (r_mode == MODE_NUMBER) || (r_mode == MODE_IDENT)
                       || (r_mode == MODE_STRING);
            fresh_v    = 1'b1;
            fresh_tok.kind   = KIND_END;
            fresh_tok.length = 8'd0;
            n_mode     = MODE_IDLE;
            n_pos      = '0;
            n_tstart   = '0;
            n_tlen     = '0;
            n_sat      = 1'b0;
            n_kwp      = '0;
            n_kwdead   = 1'b0;
        end else begin
            case (r_mode)
                MODE_NUMBER: begin
                    if (is_digit(i_ch)) begin
                        if (r_tlen < LEN_W'(MAX_TOKEN_LEN)) n_tlen = r_tlen + LEN_W'(1);
                        else n_sat = 1'b1;
                    end else begin
                        flush_v  = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_alpha(i_ch) || is_digit(i_ch) || (i_ch == CH_UNDERSCORE)) begin
                        if (r_tlen < LEN_W'(MAX_TOKEN_LEN)) n_tlen = r_tlen + LEN_W'(1);
                        else n_sat = 1'b1;
                        if (kw_hit) n_kwp = r_kwp + KW_W'(1);
                        else n_kwdead = 1'b1;
                    end else begin
                        flush_v  = 1'b1;
                        do_fresh = 1'b1;
                    end
                end
                MODE_STRING: begin
                    if (i_ch == CH_QUOTE) begin
                        flush_v = 1'b1;
                        n_mode  = MODE_IDLE;
                    end else if (r_tlen < LEN_W'(MAX_TOKEN_LEN)) begin
                        n_tlen = r_tlen + LEN_W'(1);
                    end else begin
                        n_sat = 1'b1;
                    end
                end
                MODE_ERROR: begin
                    // Bytes are dropped until the end of text.
                end
                default: begin
                    do_fresh = 1'b1;
                end
            endcase

            // Scan the byte as the start of a new token.
            if (do_fresh) begin
                n_mode = MODE_IDLE;
                if (is_space(i_ch)) begin
                    // Whitespace between tokens gives nothing.
                end else if (is_digit(i_ch)) begin
                    n_mode   = MODE_NUMBER;
                    n_tstart = r_pos;
                    n_tlen   = LEN_W'(1);
                    n_sat    = 1'b0;
                    n_kwp    = '0;
                    n_kwdead = 1'b0;
                end else if (is_alpha(i_ch)) begin
                    n_mode   = MODE_IDENT;
                    n_tstart = r_pos;
                    n_tlen   = LEN_W'(1);
                    n_sat    = 1'b0;
                    n_kwp    = (i_ch == kw_char('0)) ? KW_W'(1) : '0;
                    n_kwdead = (i_ch != kw_char('0));
                end else if (i_ch == CH_QUOTE) begin
                    // String content starts after the opening quote.
                    n_mode   = MODE_STRING;
                    n_tstart = r_pos + POS_W'(1);
                    n_tlen   = '0;
                    n_sat    = 1'b0;
                    n_kwp    = '0;
                    n_kwdead = 1'b0;
                end else begin
                    fresh_v = 1'b1;
                    if (op_kind == KIND_BAD) n_mode = MODE_ERROR;
                end
            end
        end

        // Kind of the pending token when it is closed.
        case (r_mode)
            MODE_NUMBER: flush_kind = KIND_NUMBER;
            MODE_IDENT:  flush_kind = (!r_kwdead && (r_kwp == KW_W'(KW_LEN))) ?
                                      KIND_PRINT : KIND_IDENT;
            MODE_STRING: flush_kind = text_end ? KIND_UNTERM : KIND_STRING;
            default:     flush_kind = KIND_NUMBER;
        endcase

        flush_tok.kind   = flush_kind;
        flush_tok.start  = 16'(r_tstart);
        flush_tok.length = 8'(r_tlen);
        flush_tok.ovf    = r_sat;
        flush_tok.last   = !fresh_v;
        fresh_tok.last   = 1'b1;

        // Put the tokens in order, the closed token first.
        o_res.v0   = flush_v || fresh_v;
        o_res.v1   = flush_v && fresh_v;
        o_res.tok0 = flush_v ? flush_tok : fresh_tok;
        o_res.tok1 = fresh_tok;
    end

`ifndef NO_ASSERTIONS
    // The end of text returns the scanner to its reset state.
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && text_end |=> (r_mode == MODE_IDLE) && (r_pos == '0))
        else $error("scanner not cleared after end of text");

    // The pending length never passes the saturation limit.
    a_len_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tlen <= LEN_W'(MAX_TOKEN_LEN))
        else $error("token length beyond limit");

    // An end of text always yields at least the end token, marked last.
    a_end_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        text_end |-> o_res.v0 && ((o_res.v1 ? o_res.tok1.kind : o_res.tok0.kind) == KIND_END))
        else $error("end of text without end token");

    // Error mode only leaves at end of text.
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && (r_mode == MODE_ERROR) && !text_end |=> (r_mode == MODE_ERROR))
        else $error("error mode left early");
`endif

endmodule

[rtl/core/exlex_queue.sv]
// Result queue of the expression lexer: takes up to two tokens a cycle and
// hands one word a cycle to the output stream while it is ready. Depends on exlex_pkg.
`timescale 1ns / 1ps

module exlex_queue
    import exlex_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_scan_res i_res,
    input  logic      i_pop,
    output logic      o_room,
    output logic      o_valid,
    output t_token    o_head
);

    t_token           r_q [QUEUE_DEPTH];
    t_token           n_q [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] kept;
    logic             wr0, wr1;
    logic             pop_en;

    assign pop_en  = i_pop && (r_count != '0);
    assign kept    = r_count - CNT_W'(pop_en);
    assign wr0     = i_push && i_res.v0;
    assign wr1     = i_push && i_res.v1;

    // Room for two more tokens, whatever the output side does.
    assign o_room  = (r_count <= CNT_W'(QUEUE_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_head  = r_q[0];

    // Shift on pop, then append the new tokens behind what is kept.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop_en && (i < QUEUE_DEPTH - 1)) n_q[i] = r_q[i+1];
            else n_q[i] = r_q[i];
            if (wr0 && (CNT_W'(i) == kept)) n_q[i] = i_res.tok0;
            if (wr1 && (CNT_W'(i) == kept + CNT_W'(1))) n_q[i] = i_res.tok1;
        end
        n_count = kept + CNT_W'(wr0) + CNT_W'(wr1);
    end

    // Queue entries hold payload only.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // Fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    // A push never arrives without room for two tokens.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_room)
        else $error("result queue overflow");

    // The fill level follows pushes and pops exactly.
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> r_count == $past(r_count) - CNT_W'($past(pop_en))
                 + CNT_W'($past(wr0)) + CNT_W'($past(wr1)))
        else $error("result queue count mismatch");
`endif

endmodule

[rtl/core/expression_lexer.sv]
// Top level of the expression lexer: byte scanner feeding a result queue.
// Depends on exlex_pkg, exlex_scan and exlex_queue.
//
//  Channel  Dir  Words                     Sideband
//  s_axis   in   one text byte             tlast: end of text
//  m_axis   out  one token: start, length  tuser: kind, tlast: last of byte
//
// One byte is accepted every cycle while the queue has room; its tokens are
// written to the queue at the accepting edge itself and the first can leave
// in the next cycle. A byte that closes one token and opens another yields
// two words, so a run of such bytes is limited by the single-word output port.
// s_axis_tready is high while the four-entry queue has room for two tokens.
// Reset clears the scanner to offset zero and empties the queue.
`timescale 1ns / 1ps

module expression_lexer
    import exlex_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] ch
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [15:0] start_res, [23:16] length,
                                        // [24] length_overflow, [31:25] zero
    output logic [3:0]  m_axis_tuser,   // [3:0] kind
    output logic        m_axis_tlast
);

    t_scan_res scan_res;
    t_token    head;
    logic      room;
    logic      in_acc;

    assign s_axis_tready = room;
    assign in_acc        = s_axis_tvalid && room;

    // Per-byte classification and token tracking.
    exlex_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_ch     (s_axis_tdata),
        .i_end    (s_axis_tlast),
        .o_res    (scan_res)
    );

    // Result words waiting for the output side.
    exlex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_acc),
        .i_res   (scan_res),
        .i_pop   (m_axis_tready),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    // Pack the head token onto the output word.
    assign m_axis_tdata = {7'd0, head.ovf, head.length, head.start};
    assign m_axis_tuser = head.kind;
    assign m_axis_tlast = head.last;

endmodule

[tb/tb_expression_lexer.sv]
// Self-checking testbench for expression_lexer: text bytes go in as stream words, and tokens
// are checked field by field against a token predictor kept in this file.
// Depends on exlex_pkg and the expression_lexer RTL only.
`timescale 1ns / 1ps

module tb_expression_lexer;
    import exlex_pkg::*;

    // The keyword, first character in the top byte.
    localparam logic [39:0] KEYWORD = "print";
    localparam int RANDOM_ITEMS = 400;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;  // [7:0] ch
    logic        s_axis_tlast = 1'b0;   // end of text
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;          // [15:0] start, [23:16] length, [24] overflow
    logic [3:0]  m_axis_tuser;          // [3:0] kind
    logic        m_axis_tlast;          // last token of the byte

    // Tokens the predictor has produced and the block has not yet sent.
    t_token pending_tokens[$];
    t_token step_tokens[$];
    int     n_errors = 0;
    int     live_items = 0;

    // Predictor state.
    t_mode            lx_mode = MODE_IDLE;
    logic [POS_W-1:0] lx_pos = '0;
    logic [POS_W-1:0] tok_start = '0;
    int               tok_len = 0;
    logic             tok_sat = 1'b0;
    int               kw_hits = 0;
    logic             kw_miss = 1'b0;

    // Sender burst state and receiver stall state.
    int   burst_left = 0;
    logic steady_send = 1'b0;
    int   rx_hold_req = 0;
    int   rx_hold_left = 0;
    int   rx_style = 0;
    int   rx_phase = 0;
    int   rx_tick = 0;

    expression_lexer u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Token predictor
    // ------------------------------------------------------------------
    function automatic logic digit_ch(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic letter_ch(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic blank_ch(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    task automatic add_token(input t_kind k, input logic [POS_W-1:0] s, input int len,
                             input logic ovf);
        t_token t;
        t.kind   = k;
        t.start  = 16'(s);
        t.length = 8'(len);
        t.ovf    = ovf;
        t.last   = 1'b0;
        step_tokens.push_back(t);
    endtask

    task automatic open_token(input t_mode m, input logic [POS_W-1:0] s);
        lx_mode   = m;
        tok_start = s;
        tok_len   = 0;
        tok_sat   = 1'b0;
        kw_hits   = 0;
        kw_miss   = 1'b0;
    endtask

    // Length counts up to the maximum, then only the overflow flag moves.
    task automatic grow_token();
        if (tok_len < MAX_TOKEN_LEN) tok_len++;
        else tok_sat = 1'b1;
    endtask

    task automatic track_keyword(input logic [7:0] c);
        if (!kw_miss && kw_hits < KW_LEN && c == KEYWORD[39 - 8*kw_hits -: 8]) kw_hits++;
        else kw_miss = 1'b1;
    endtask

    task automatic close_word();
        if (lx_mode == MODE_NUMBER) begin
            add_token(KIND_NUMBER, tok_start, tok_len, tok_sat);
        end else if (lx_mode == MODE_IDENT) begin
            if (!kw_miss && kw_hits == KW_LEN) add_token(KIND_PRINT, tok_start, tok_len, tok_sat);
            else add_token(KIND_IDENT, tok_start, tok_len, tok_sat);
        end
        lx_mode = MODE_IDLE;
    endtask

    // A byte seen with no token open.
    task automatic scan_fresh(input logic [7:0] c);
        lx_mode = MODE_IDLE;
        if (blank_ch(c)) return;
        if (digit_ch(c)) begin
            open_token(MODE_NUMBER, lx_pos);
            grow_token();
        end else if (letter_ch(c)) begin
            open_token(MODE_IDENT, lx_pos);
            grow_token();
            track_keyword(c);
        end else if (c == CH_QUOTE) begin
            open_token(MODE_STRING, lx_pos + 1'b1);
        end else begin
            case (c)
                CH_PLUS:   add_token(KIND_PLUS, lx_pos, 1, 1'b0);
                CH_MINUS:  add_token(KIND_MINUS, lx_pos, 1, 1'b0);
                CH_STAR:   add_token(KIND_MUL, lx_pos, 1, 1'b0);
                CH_SLASH:  add_token(KIND_DIV, lx_pos, 1, 1'b0);
                CH_LPAREN: add_token(KIND_LPAREN, lx_pos, 1, 1'b0);
                CH_RPAREN: add_token(KIND_RPAREN, lx_pos, 1, 1'b0);
                CH_EQUALS: add_token(KIND_ASSIGN, lx_pos, 1, 1'b0);
                CH_SEMI:   add_token(KIND_SEMI, lx_pos, 1, 1'b0);
                default: begin
                    add_token(KIND_BAD, lx_pos, 1, 1'b0);
                    lx_mode = MODE_ERROR;
                end
            endcase
        end
    endtask

    // Works out the tokens one accepted byte causes and queues them.
    task automatic tokenise_byte(input logic [7:0] c, input logic eot);
        step_tokens.delete();
        if (eot || c == CH_NUL || lx_mode != MODE_ERROR) live_items++;
        if (eot || c == CH_NUL) begin
            if (lx_mode == MODE_NUMBER || lx_mode == MODE_IDENT) close_word();
            else if (lx_mode == MODE_STRING) add_token(KIND_UNTERM, tok_start, tok_len, tok_sat);
            add_token(KIND_END, lx_pos, 0, 1'b0);
            open_token(MODE_IDLE, '0);
            lx_pos = '0;
        end else begin
            case (lx_mode)
                MODE_NUMBER: begin
                    if (digit_ch(c)) grow_token();
                    else begin
                        close_word();
                        scan_fresh(c);
                    end
                end
                MODE_IDENT: begin
                    if (letter_ch(c) || digit_ch(c) || c == CH_UNDERSCORE) begin
                        grow_token();
                        track_keyword(c);
                    end else begin
                        close_word();
                        scan_fresh(c);
                    end
                end
                MODE_STRING: begin
                    if (c == CH_QUOTE) begin
                        add_token(KIND_STRING, tok_start, tok_len, tok_sat);
                        lx_mode = MODE_IDLE;
                    end else begin
                        grow_token();
                    end
                end
                MODE_ERROR: ;
                default: scan_fresh(c);
            endcase
            lx_pos = lx_pos + 1'b1;
        end
        if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i]) pending_tokens.push_back(step_tokens[i]);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // Every token word taken by the receiver is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_token want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_tokens.size() == 0) begin
                $error("token word with none predicted: kind %0d start %0d",
                       m_axis_tuser, m_axis_tdata[15:0]);
                n_errors++;
            end else begin
                want = pending_tokens.pop_front();
                check_field("kind", 32'(want.kind), 32'(m_axis_tuser));
                check_field("start", 32'(want.start), 32'(m_axis_tdata[15:0]));
                check_field("length", 32'(want.length), 32'(m_axis_tdata[23:16]));
                check_field("length_overflow", 32'(want.ovf), 32'(m_axis_tdata[24]));
                check_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changes its stall pattern now and then; a hold request from a
    // test makes it refuse words until the requested hold has run out.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        rx_tick++;
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            if (rx_phase == 0) begin
                rx_style = $urandom_range(0, 3);
                rx_phase = $urandom_range(20, 200);
            end
            rx_phase--;
            case (rx_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= 1'($urandom_range(0, 1));
                2:       m_axis_tready <= ($urandom_range(0, 4) != 0);
                default: m_axis_tready <= (rx_tick % 4 != 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------
    // Offers one byte from a falling edge, waits for the handshake and returns on a
    // falling edge, after a gap if the current burst has ended and sending is not steady.
    task automatic send_byte(input logic [7:0] c, input logic eot);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= eot;
        do @(posedge i_clk); while (!s_axis_tready);
        tokenise_byte(c, eot);
        @(negedge i_clk);
        if (!steady_send) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, 10);
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
                if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(50, 150);
                else burst_left = $urandom_range(1, 20);
            end else begin
                burst_left--;
            end
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
    endtask

    task automatic send_run(input logic [7:0] c, input int n);
        repeat (n) send_byte(c, 1'b0);
    endtask

    // End of text, by the end flag with any byte, or by a zero byte.
    task automatic end_text();
        if ($urandom_range(0, 3) == 0) send_byte(CH_NUL, 1'b0);
        else send_byte(8'($urandom_range(0, 255)), 1'b1);
    endtask

    // Sender goes quiet until every predicted token has come out.
    task automatic drain_tokens();
        s_axis_tvalid <= 1'b0;
        while (pending_tokens.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [7:0] op_char(input int idx);
        case (idx)
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_STAR;
            3:       return CH_SLASH;
            4:       return CH_LPAREN;
            5:       return CH_RPAREN;
            6:       return CH_EQUALS;
            default: return CH_SEMI;
        endcase
    endfunction

    function automatic logic [7:0] word_char();
        int r;
        r = $urandom_range(0, 62);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 36) return 8'(8'h41 + (r - 10));
        if (r < 62) return 8'(8'h61 + (r - 36));
        return CH_UNDERSCORE;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Every token class, whitespace, both ways of ending a text, an unterminated
    // string, an unknown byte followed by ignored bytes, and a high byte at the start.
    task automatic test_token_classes();
        send_text("print\t\"s\"+9*(a_)/-=;");
        send_byte(8'hC3, 1'b1);
        send_text("\"x");
        send_byte(CH_NUL, 1'b0);
        send_byte(CH_UNDERSCORE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(CH_SEMI, 1'b0);
        send_byte(CH_NUL, 1'b1);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b1);
        drain_tokens();
    endtask

    // Tokens past the length limit in every class that has a length, and an identifier at it.
    task automatic test_long_tokens();
        send_run(8'h37, MAX_TOKEN_LEN + 1);
        end_text();
        send_byte(8'h61, 1'b0);
        send_run(8'h7A, MAX_TOKEN_LEN - 1);
        send_byte(CH_SPACE, 1'b0);
        send_byte(8'h62, 1'b0);
        send_run(8'h5F, MAX_TOKEN_LEN);
        send_byte(CH_SEMI, 1'b0);
        end_text();
        send_byte(CH_QUOTE, 1'b0);
        send_run(8'h71, MAX_TOKEN_LEN + 1);
        send_byte(CH_QUOTE, 1'b0);
        send_byte(CH_QUOTE, 1'b0);
        send_run(8'h71, MAX_TOKEN_LEN + 1);
        end_text();
        drain_tokens();
    endtask

    // The receiver holds off for a long stretch while digits alternate with operator
    // bytes that each close a number and emit an operator, so the block must stall its input.
    task automatic test_backpressure();
        steady_send = 1'b1;
        rx_hold_req = 150;
        for (int i = 0; i < 40; i++) begin
            send_byte(8'(8'h30 + (i % 10)), 1'b0);
            send_byte(op_char(i % 8), 1'b0);
        end
        end_text();
        steady_send = 1'b0;
        drain_tokens();
    endtask

    // One random token, mostly well formed; now and then noise or an end of text.
    task automatic send_random_token();
        int        r;
        int        n;
        logic [7:0] c;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'(8'h30 + $urandom_range(0, 9)), 1'b0);
        end else if (r < 50) begin
            case ($urandom_range(0, 5))
                0, 1: send_text("print");
                2:    send_text("prin");
                3:    send_text("printer_1");
                default: begin
                    if ($urandom_range(0, 1)) send_byte(8'(8'h41 + $urandom_range(0, 25)), 1'b0);
                    else send_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
                    n = $urandom_range(0, 7);
                    repeat (n) send_byte(word_char(), 1'b0);
                end
            endcase
        end else if (r < 62) begin
            send_byte(CH_QUOTE, 1'b0);
            n = $urandom_range(0, 8);
            repeat (n) begin
                c = 8'($urandom_range(1, 254));
                if (c >= CH_QUOTE) c = c + 1'b1;
                send_byte(c, 1'b0);
            end
            if ($urandom_range(0, 11) == 0) end_text();
            else send_byte(CH_QUOTE, 1'b0);
        end else if (r < 82) begin
            send_byte(op_char($urandom_range(0, 7)), 1'b0);
        end else if (r < 95) begin
            n = $urandom_range(1, 3);
            repeat (n) begin
                r = $urandom_range(0, 5);
                send_byte((r == 5) ? CH_SPACE : 8'(CH_TAB + r), 1'b0);
            end
        end else if (r < 96) begin
            send_byte(8'($urandom_range(1, 255)), 1'b0);
        end else begin
            end_text();
        end
    endtask

    task automatic test_random_text();
        int target;
        target = live_items + RANDOM_ITEMS;
        while (live_items < target) send_random_token();
        end_text();
        drain_tokens();
    endtask

    initial begin
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_token_classes();
        test_long_tokens();
        test_backpressure();
        test_random_text();
        repeat (20) @(negedge i_clk);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #(10_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
